FILE: design/stable_priority_task_queue_core_defines.svh
// ----------------------------------------------------------------------------
// Stable priority task queue: assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_TASK_QUEUE_CORE_DEFINES_SVH
`define STABLE_PRIORITY_TASK_QUEUE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// Stable priority task queue: shared package
// Defaults, port widths, opcodes, controller states and command structs.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Parameter defaults
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned ID_WIDTH_DEF   = 8;
  localparam int unsigned PRIO_WIDTH_DEF = 8;

  // Fixed port widths
  localparam int unsigned ID_PORT_W   = 8;
  localparam int unsigned PRIO_PORT_W = 8;
  localparam int unsigned OCC_PORT_W  = 5;

  // Opcodes
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // Controller states: no result held / result held for output
  typedef enum logic {
    S_EMPTY,
    S_HOLD
  } ctl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic store;    // insert the new entry into the chain
    logic pop;      // remove the head entry
    logic drop;     // enqueue refused, queue full
    logic capture;  // load the result register
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
  } dp_status_t;

endpackage

FILE: design/stable_priority_task_queue_core.sv
// Latency: a result is valid in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the output side keeps taking results;
// the single result register is the limit; the chain update is combinational.
// Reset: synchronous, active high; empties the queue and drops any held result.
// No clearing pass: valid bits reset at once, the block is ready next cycle.
// ----------------------------------------------------------------------------
// Stable priority task queue core
// Bounded stable priority queue of task handles built from a controller FSM
// and a shift-insert cell-chain datapath.
// ----------------------------------------------------------------------------
module stable_priority_task_queue_core #(
  parameter int unsigned DEPTH      = spq_pkg::DEPTH_DEF,
  parameter int unsigned ID_WIDTH   = spq_pkg::ID_WIDTH_DEF,
  parameter int unsigned PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            opcode,
  input  logic [spq_pkg::ID_PORT_W-1:0]   task_id,
  input  logic [spq_pkg::PRIO_PORT_W-1:0] task_priority,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            head_valid,
  output logic [spq_pkg::ID_PORT_W-1:0]   head_task,
  output logic [spq_pkg::PRIO_PORT_W-1:0] head_priority,
  output logic                            dropped,
  output logic [spq_pkg::OCC_PORT_W-1:0]  occupancy
);
  import spq_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  // Handshake and command control
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Cell chain and result register
  spq_datapath #(
    .DEPTH      (DEPTH),
    .ID_WIDTH   (ID_WIDTH),
    .PRIO_WIDTH (PRIO_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .task_id       (task_id),
    .task_priority (task_priority),
    .cmd           (cmd),
    .status        (status),
    .head_valid    (head_valid),
    .head_task     (head_task),
    .head_priority (head_priority),
    .dropped       (dropped),
    .occupancy     (occupancy)
  );

endmodule

FILE: design/spq_ctrl.sv
// ----------------------------------------------------------------------------
// Stable priority task queue: controller
// Handshake FSM that accepts one beat, issues the cell-chain command and
// holds the result until the output side takes it.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                opcode,
  output logic                out_valid,
  input  logic                out_ready,
  input  spq_pkg::dp_status_t status,
  output spq_pkg::ctl_cmd_t   cmd
);
  import spq_pkg::*;

  ctl_state_t state, state_next;
  logic       accept;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_EMPTY: begin
        in_ready = 1'b1;
      end
      S_HOLD: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase

    accept = in_valid && in_ready;
    if (accept) begin
      state_next = S_HOLD;
    end else if (state == S_HOLD && out_ready) begin
      state_next = S_EMPTY;
    end

    cmd.capture = accept;
    cmd.store   = accept && (opcode == OP_ENQUEUE) && !status.full;
    cmd.drop    = accept && (opcode == OP_ENQUEUE) && status.full;
    cmd.pop     = accept && (opcode == OP_DEQUEUE) && !status.empty;
  end

endmodule

FILE: design/spq_datapath.sv
// ----------------------------------------------------------------------------
// Stable priority task queue: datapath
// Shift-insert cell chain kept in service order, fill count and the
// result register.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int unsigned DEPTH      = spq_pkg::DEPTH_DEF,
  parameter int unsigned ID_WIDTH   = spq_pkg::ID_WIDTH_DEF,
  parameter int unsigned PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [spq_pkg::ID_PORT_W-1:0]      task_id,
  input  logic [spq_pkg::PRIO_PORT_W-1:0]    task_priority,
  input  spq_pkg::ctl_cmd_t                  cmd,
  output spq_pkg::dp_status_t                status,
  output logic                               head_valid,
  output logic [spq_pkg::ID_PORT_W-1:0]      head_task,
  output logic [spq_pkg::PRIO_PORT_W-1:0]    head_priority,
  output logic                               dropped,
  output logic [spq_pkg::OCC_PORT_W-1:0]     occupancy
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Cell chain
  logic [ID_WIDTH-1:0]   cell_task [DEPTH];
  logic [PRIO_WIDTH-1:0] cell_prio [DEPTH];
  logic [DEPTH-1:0]      valid;
  logic [CW-1:0]         count;

  logic [ID_WIDTH-1:0]   new_task;
  logic [PRIO_WIDTH-1:0] new_prio;
  logic [ID_WIDTH+ID_PORT_W-1:0]     id_in_wide;
  logic [PRIO_WIDTH+PRIO_PORT_W-1:0] prio_in_wide;

  logic [ID_WIDTH-1:0]   up_task [DEPTH];
  logic [PRIO_WIDTH-1:0] up_prio [DEPTH];
  logic [ID_WIDTH-1:0]   dn_task [DEPTH];
  logic [PRIO_WIDTH-1:0] dn_prio [DEPTH];
  logic [DEPTH-1:0]      le, le_prev, valid_up, valid_dn;

  logic [ID_WIDTH-1:0]   cell_task_next [DEPTH];
  logic [PRIO_WIDTH-1:0] cell_prio_next [DEPTH];
  logic [DEPTH-1:0]      valid_next;
  logic [CW-1:0]         count_next;

  logic [ID_WIDTH+ID_PORT_W-1:0]     id_out_wide;
  logic [PRIO_WIDTH+PRIO_PORT_W-1:0] prio_out_wide;
  logic [CW+OCC_PORT_W-1:0]          occ_out_wide;

  // Fit incoming fields to the stored widths
  assign id_in_wide   = {{ID_WIDTH{1'b0}}, task_id};
  assign prio_in_wide = {{PRIO_WIDTH{1'b0}}, task_priority};
  assign new_task     = id_in_wide[ID_WIDTH-1:0];
  assign new_prio     = prio_in_wide[PRIO_WIDTH-1:0];

  assign status.full  = valid[DEPTH-1];
  assign status.empty = !valid[0];

  // Neighbor views and per-cell compare
  always_comb begin
    up_task[0]  = new_task;
    up_prio[0]  = new_prio;
    le_prev[0]  = 1'b1;
    valid_up[0] = 1'b1;
    for (int i = 1; i < DEPTH; i++) begin
      up_task[i]  = cell_task[i-1];
      up_prio[i]  = cell_prio[i-1];
      valid_up[i] = valid[i-1];
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      dn_task[i]  = cell_task[i+1];
      dn_prio[i]  = cell_prio[i+1];
      valid_dn[i] = valid[i+1];
    end
    dn_task[DEPTH-1]  = cell_task[DEPTH-1];
    dn_prio[DEPTH-1]  = cell_prio[DEPTH-1];
    valid_dn[DEPTH-1] = 1'b0;
    // le is a prefix: stored entries stay sorted
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = valid[i] && (cell_prio[i] <= new_prio);
    end
    for (int i = 1; i < DEPTH; i++) begin
      le_prev[i] = le[i-1];
    end
  end

  // Next chain contents
  always_comb begin
    valid_next = valid;
    count_next = count;
    for (int i = 0; i < DEPTH; i++) begin
      cell_task_next[i] = cell_task[i];
      cell_prio_next[i] = cell_prio[i];
    end
    if (cmd.store) begin
      count_next = count + CW'(1);
      valid_next = valid | valid_up;
      for (int i = 0; i < DEPTH; i++) begin
        if (!le[i]) begin
          // insertion point takes the new entry, cells behind shift back
          cell_task_next[i] = le_prev[i] ? new_task : up_task[i];
          cell_prio_next[i] = le_prev[i] ? new_prio : up_prio[i];
        end
      end
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
      valid_next = valid_dn;
      for (int i = 0; i < DEPTH; i++) begin
        cell_task_next[i] = dn_task[i];
        cell_prio_next[i] = dn_prio[i];
      end
    end
  end

  // Result fields fitted to the port widths
  assign id_out_wide   = {{ID_PORT_W{1'b0}}, cell_task[0]};
  assign prio_out_wide = {{PRIO_PORT_W{1'b0}}, cell_prio[0]};
  assign occ_out_wide  = {{OCC_PORT_W{1'b0}}, count_next};

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else begin
      valid <= valid_next;
      count <= count_next;
    end
  end

  // Cell payload, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_task[i] <= cell_task_next[i];
      cell_prio[i] <= cell_prio_next[i];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      head_valid    <= cmd.pop;
      head_task     <= cmd.pop ? id_out_wide[ID_PORT_W-1:0] : '0;
      head_priority <= cmd.pop ? prio_out_wide[PRIO_PORT_W-1:0] : '0;
      dropped       <= cmd.drop;
      occupancy     <= occ_out_wide[OCC_PORT_W-1:0];
    end
  end

endmodule

FILE: design/spq_checker.sv
// ----------------------------------------------------------------------------
// Stable priority task queue: port checker
// Concurrent assertions on the top-level ports, bound to the core.
// ----------------------------------------------------------------------------
`include "stable_priority_task_queue_core_defines.svh"

module spq_checker #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            head_valid,
  input logic [spq_pkg::ID_PORT_W-1:0]   head_task,
  input logic [spq_pkg::PRIO_PORT_W-1:0] head_priority,
  input logic                            dropped,
  input logic [spq_pkg::OCC_PORT_W-1:0]  occupancy
);
  import spq_pkg::*;

  localparam logic [OCC_PORT_W-1:0] FULL_OCC = OCC_PORT_W'(DEPTH);

  // Stalled result beat holds
  `SPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(head_valid) && $stable(head_task) &&
    $stable(head_priority) && $stable(dropped) && $stable(occupancy),
    "stalled result beat changed")

  // Every accepted beat gives a result in the next cycle
  `SPQ_ASSERT_NEXT(a_accept_result, in_valid && in_ready, out_valid,
    "accepted beat produced no result")

  // A dequeue hit and a drop never come together
  `SPQ_ASSERT_NOW(a_hit_no_drop, out_valid && head_valid, !dropped,
    "dequeue result flagged as dropped")

  // No entry returned means zero head fields
  `SPQ_ASSERT_NOW(a_miss_zero, out_valid && !head_valid,
    head_task == '0 && head_priority == '0,
    "head fields nonzero without an entry")

  // A drop only happens at full occupancy
  `SPQ_ASSERT_NOW(a_drop_full, out_valid && dropped, occupancy == FULL_OCC,
    "drop reported below full occupancy")

endmodule

bind stable_priority_task_queue_core spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .head_valid    (head_valid),
  .head_task     (head_task),
  .head_priority (head_priority),
  .dropped       (dropped),
  .occupancy     (occupancy)
);
